FILE: rtl/crr_pkg.sv
// ----------------------------------------------------------------------------
// crr_pkg
// Shared types and constants for the code range registry.
// ----------------------------------------------------------------------------
package crr_pkg;

	localparam int DEF_MAX_IMAGES = 16;
	localparam int DEF_MAX_RANGES = 8;

	localparam logic [1:0] CLS_UNKNOWN = 2'd0;
	localparam logic [1:0] CLS_OTHER   = 2'd2;

	typedef enum logic [2:0] {
		CMD_OPEN   = 3'd0,
		CMD_HEADER = 3'd1,
		CMD_COMMIT = 3'd2,
		CMD_UNREG  = 3'd3,
		CMD_LOOKUP = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE       = 2'd0,
		ST_IGNORED    = 2'd1,
		ST_TABLE_FULL = 2'd2,
		ST_RANGE_FULL = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HDR,
		S_CSCAN,
		S_CCOPY,
		S_USCAN,
		S_UREAD,
		S_UMOVE,
		S_UCOPY,
		S_LIMG,
		S_LHDR,
		S_LRNG,
		S_FINISH
	} state_t;

	// segment check result, valid for one cycle
	typedef struct packed {
		logic        valid;
		logic        keep;
		logic [63:0] lo;
		logic [63:0] hi;
	} seg_res_t;

endpackage

FILE: rtl/crr_seg_chk.sv
// ----------------------------------------------------------------------------
// crr_seg_chk
// Two-stage segment filter: start = base + vaddr, end = start + memsz; keeps
// only load+exec, non-empty segments, with carry-out rejection of overflowing ranges.
// ----------------------------------------------------------------------------
module crr_seg_chk (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [63:0]       base,
	input  logic              is_load,
	input  logic              is_exec,
	input  logic [63:0]       vaddr,
	input  logic [63:0]       memsz,
	output crr_pkg::seg_res_t res
);
	import crr_pkg::*;

	logic        v_s1;
	logic        ok_s1;
	logic [63:0] start_s1;
	logic [63:0] memsz_s1;
	logic        v_s2;
	logic        keep_s2;
	logic [63:0] lo_s2;
	logic [63:0] hi_s2;

	logic [64:0] sum1;
	logic [64:0] sum2;

	assign sum1 = {1'b0, base} + {1'b0, vaddr};
	assign sum2 = {1'b0, start_s1} + {1'b0, memsz_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= go;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1    <= is_load & is_exec & (memsz != 64'd0) & ~sum1[64];
		start_s1 <= sum1[63:0];
		memsz_s1 <= memsz;
		keep_s2  <= ok_s1 & ~sum2[64];
		lo_s2    <= start_s1;
		hi_s2    <= sum2[63:0];
	end

	assign res = '{valid: v_s2, keep: keep_s2, lo: lo_s2, hi: hi_s2};

endmodule

FILE: rtl/code_range_registry.sv
// ----------------------------------------------------------------------------
// code_range_registry
// Table of loaded images with executable code ranges: staged build through
// open/header/commit, swap-remove unregister, and first-match address lookup.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_ready | command, base_addr, image_class, seg_*,
//          |                     | lookup_address
//  out     | out_valid/out_ready | status, hit, range_start, range_end,
//          |                     | class_out, generation_count
//
//  One word at a time. Open and ignored words go straight to the result,
//  header waits for the segment filter, commit scans the images for a
//  matching base and then copies the staged ranges, unregister scans, moves
//  the last image into the freed slot and copies its ranges. Lookup scans
//  the images in order and each one's ranges one at a time through the
//  single read port of the range memory.
//  Reset clears counts and staging only; tables need no clearing pass.
//  A result waits in the output register; the next word is taken meanwhile.
// ----------------------------------------------------------------------------
module code_range_registry #(
	parameter int MAX_IMAGES = crr_pkg::DEF_MAX_IMAGES,
	parameter int MAX_RANGES = crr_pkg::DEF_MAX_RANGES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [63:0] base_addr,
	input  logic [1:0]  image_class,
	input  logic        seg_is_load,
	input  logic        seg_is_exec,
	input  logic [63:0] seg_vaddr,
	input  logic [63:0] seg_memsz,
	input  logic [63:0] lookup_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        hit,
	output logic [63:0] range_start,
	output logic [63:0] range_end,
	output logic [1:0]  class_out,
	output logic [63:0] generation_count
);
	import crr_pkg::*;

	localparam int IMG_CNT_W  = $clog2(MAX_IMAGES + 1);
	localparam int IMG_IDX_W  = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;
	localparam int RNG_CNT_W  = $clog2(MAX_RANGES + 1);
	localparam int RNG_IDX_W  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int RNG_DEPTH  = MAX_IMAGES * MAX_RANGES;
	localparam int RNG_ADDR_W = (RNG_DEPTH > 1) ? $clog2(RNG_DEPTH) : 1;

	function automatic logic [RNG_ADDR_W-1:0] rng_addr(
		input logic [IMG_IDX_W-1:0] img,
		input logic [RNG_IDX_W-1:0] pos
	);
		return RNG_ADDR_W'(img) * RNG_ADDR_W'(MAX_RANGES) + RNG_ADDR_W'(pos);
	endfunction

	// memories
	logic [63:0]          img_base_mem [MAX_IMAGES];
	logic [1:0]           img_kind_mem [MAX_IMAGES];
	logic [RNG_CNT_W-1:0] img_rcnt_mem [MAX_IMAGES];
	logic [63:0]          rng_lo_mem   [RNG_DEPTH];
	logic [63:0]          rng_hi_mem   [RNG_DEPTH];
	logic [63:0]          stg_lo_mem   [MAX_RANGES];
	logic [63:0]          stg_hi_mem   [MAX_RANGES];

	logic                  img_we;
	logic [IMG_IDX_W-1:0]  img_waddr, img_raddr;
	logic [63:0]           img_wbase;
	logic [1:0]            img_wkind;
	logic [RNG_CNT_W-1:0]  img_wcnt;
	logic [63:0]           img_rd_base_q;
	logic [1:0]            img_rd_kind_q;
	logic [RNG_CNT_W-1:0]  img_rd_cnt_q;

	logic                  rng_we;
	logic [RNG_ADDR_W-1:0] rng_waddr, rng_raddr;
	logic [63:0]           rng_wlo, rng_whi;
	logic [63:0]           rng_rd_lo_q, rng_rd_hi_q;

	logic                  stg_we;
	logic [RNG_IDX_W-1:0]  stg_waddr, stg_raddr;
	logic [63:0]           stg_rd_lo_q, stg_rd_hi_q;

	// control state
	state_t               state_q, state_d;
	logic [IMG_CNT_W-1:0] img_cnt_q, img_cnt_d;
	logic [63:0]          gen_q, gen_d;
	logic [63:0]          stg_base_q, stg_base_d;
	logic [1:0]           stg_kind_q, stg_kind_d;
	logic [RNG_CNT_W-1:0] stg_cnt_q, stg_cnt_d;
	logic [IMG_CNT_W-1:0] i_q, i_d;
	logic [RNG_CNT_W-1:0] p_q, p_d;
	logic                 pend_q, pend_d;
	logic                 out_valid_q, out_valid_d;

	// payload state
	logic [63:0]          bias_q, bias_d;
	logic [63:0]          addr_q, addr_d;
	logic [IMG_CNT_W-1:0] pidx_q, pidx_d;
	logic [RNG_IDX_W-1:0] ppos_q, ppos_d;
	logic [IMG_IDX_W-1:0] tgt_q, tgt_d;
	logic [IMG_IDX_W-1:0] src_q, src_d;
	logic [RNG_CNT_W-1:0] n_q, n_d;
	logic [1:0]           kind_q, kind_d;
	status_t              res_status_q, res_status_d;
	logic                 res_hit_q, res_hit_d;
	logic [63:0]          res_lo_q, res_lo_d;
	logic [63:0]          res_hi_q, res_hi_d;
	logic [1:0]           res_cls_q, res_cls_d;
	logic                 out_load;
	logic [1:0]           out_status_q;
	logic                 out_hit_q;
	logic [63:0]          out_lo_q, out_hi_q, out_gen_q;
	logic [1:0]           out_cls_q;

	logic                 seg_go;
	seg_res_t             seg_res;
	logic [63:0]          scan_key;
	logic                 scan_match;
	logic                 range_match;

	crr_seg_chk u_seg_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (seg_go),
		.base    (stg_base_q),
		.is_load (seg_is_load),
		.is_exec (seg_is_exec),
		.vaddr   (seg_vaddr),
		.memsz   (seg_memsz),
		.res     (seg_res)
	);

	always_ff @(posedge clk) begin
		if (img_we) begin
			img_base_mem[img_waddr] <= img_wbase;
			img_kind_mem[img_waddr] <= img_wkind;
			img_rcnt_mem[img_waddr] <= img_wcnt;
		end
		img_rd_base_q <= img_base_mem[img_raddr];
		img_rd_kind_q <= img_kind_mem[img_raddr];
		img_rd_cnt_q  <= img_rcnt_mem[img_raddr];
	end

	always_ff @(posedge clk) begin
		if (rng_we) begin
			rng_lo_mem[rng_waddr] <= rng_wlo;
			rng_hi_mem[rng_waddr] <= rng_whi;
		end
		rng_rd_lo_q <= rng_lo_mem[rng_raddr];
		rng_rd_hi_q <= rng_hi_mem[rng_raddr];
	end

	always_ff @(posedge clk) begin
		if (stg_we) begin
			stg_lo_mem[stg_waddr] <= seg_res.lo;
			stg_hi_mem[stg_waddr] <= seg_res.hi;
		end
		stg_rd_lo_q <= stg_lo_mem[stg_raddr];
		stg_rd_hi_q <= stg_hi_mem[stg_raddr];
	end

	assign scan_key    = (state_q == S_CSCAN) ? stg_base_q : bias_q;
	assign scan_match  = pend_q && (img_rd_base_q == scan_key);
	assign range_match = pend_q && (addr_q >= rng_rd_lo_q) && (addr_q < rng_rd_hi_q);

	always_comb begin
		state_d      = state_q;
		img_cnt_d    = img_cnt_q;
		gen_d        = gen_q;
		stg_base_d   = stg_base_q;
		stg_kind_d   = stg_kind_q;
		stg_cnt_d    = stg_cnt_q;
		i_d          = i_q;
		p_d          = p_q;
		pend_d       = 1'b0;
		out_valid_d  = out_valid_q && !out_ready;
		bias_d       = bias_q;
		addr_d       = addr_q;
		pidx_d       = pidx_q;
		ppos_d       = ppos_q;
		tgt_d        = tgt_q;
		src_d        = src_q;
		n_d          = n_q;
		kind_d       = kind_q;
		res_status_d = res_status_q;
		res_hit_d    = res_hit_q;
		res_lo_d     = res_lo_q;
		res_hi_d     = res_hi_q;
		res_cls_d    = res_cls_q;
		out_load     = 1'b0;
		seg_go       = 1'b0;
		in_ready     = (state_q == S_IDLE);

		img_we    = 1'b0;
		img_waddr = tgt_q;
		img_wbase = img_rd_base_q;
		img_wkind = img_rd_kind_q;
		img_wcnt  = img_rd_cnt_q;
		img_raddr = i_q[IMG_IDX_W-1:0];
		rng_we    = 1'b0;
		rng_waddr = rng_addr(tgt_q, ppos_q);
		rng_wlo   = stg_rd_lo_q;
		rng_whi   = stg_rd_hi_q;
		rng_raddr = rng_addr(i_q[IMG_IDX_W-1:0], p_q[RNG_IDX_W-1:0]);
		stg_we    = 1'b0;
		stg_waddr = stg_cnt_q[RNG_IDX_W-1:0];
		stg_raddr = p_q[RNG_IDX_W-1:0];

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					bias_d       = base_addr;
					addr_d       = lookup_address;
					res_status_d = ST_IGNORED;
					res_hit_d    = 1'b0;
					res_lo_d     = 64'd0;
					res_hi_d     = 64'd0;
					res_cls_d    = CLS_UNKNOWN;
					i_d          = '0;
					p_d          = '0;
					state_d      = S_FINISH;
					case (command)
						CMD_OPEN: begin
							stg_base_d = base_addr;
							stg_cnt_d  = '0;
							stg_kind_d = CLS_UNKNOWN;
							if (base_addr != 64'd0) begin
								stg_kind_d   = (image_class > CLS_OTHER) ? CLS_OTHER
								                                         : image_class;
								res_status_d = ST_DONE;
							end
						end
						CMD_HEADER: begin
							if (stg_base_q != 64'd0) begin
								seg_go  = 1'b1;
								state_d = S_HDR;
							end
						end
						CMD_COMMIT: begin
							if (stg_base_q != 64'd0) state_d = S_CSCAN;
						end
						CMD_UNREG: state_d = S_USCAN;
						CMD_LOOKUP: begin
							if (img_cnt_q != '0) state_d = S_LIMG;
						end
						default: ;
					endcase
				end
			end

			S_HDR: begin
				if (seg_res.valid) begin
					state_d = S_FINISH;
					if (seg_res.keep) begin
						if (stg_cnt_q >= RNG_CNT_W'(MAX_RANGES)) begin
							res_status_d = ST_RANGE_FULL;
						end else begin
							stg_we       = 1'b1;
							stg_cnt_d    = stg_cnt_q + RNG_CNT_W'(1);
							res_status_d = ST_DONE;
						end
					end
				end
			end

			S_CSCAN, S_USCAN: begin
				if (scan_match) begin
					if (state_q == S_CSCAN) begin
						tgt_d   = pidx_q[IMG_IDX_W-1:0];
						p_d     = '0;
						state_d = S_CCOPY;
					end else begin
						img_cnt_d = img_cnt_q - IMG_CNT_W'(1);
						if (pidx_q != img_cnt_q - IMG_CNT_W'(1)) begin
							tgt_d   = pidx_q[IMG_IDX_W-1:0];
							src_d   = img_cnt_d[IMG_IDX_W-1:0];
							state_d = S_UREAD;
						end else begin
							gen_d        = gen_q + 64'd1;
							res_status_d = ST_DONE;
							state_d      = S_FINISH;
						end
					end
				end else if (!pend_q && i_q >= img_cnt_q) begin
					if (state_q == S_USCAN) begin
						state_d = S_FINISH;
					end else if (img_cnt_q == IMG_CNT_W'(MAX_IMAGES)) begin
						res_status_d = ST_TABLE_FULL;
						stg_base_d   = 64'd0;
						stg_kind_d   = CLS_UNKNOWN;
						stg_cnt_d    = '0;
						state_d      = S_FINISH;
					end else begin
						tgt_d     = img_cnt_q[IMG_IDX_W-1:0];
						img_cnt_d = img_cnt_q + IMG_CNT_W'(1);
						p_d       = '0;
						state_d   = S_CCOPY;
					end
				end else if (i_q < img_cnt_q) begin
					pend_d = 1'b1;
					pidx_d = i_q;
					i_d    = i_q + IMG_CNT_W'(1);
				end
			end

			S_CCOPY: begin
				rng_we = pend_q;
				if (!pend_q && p_q >= stg_cnt_q) begin
					img_we       = 1'b1;
					img_wbase    = stg_base_q;
					img_wkind    = stg_kind_q;
					img_wcnt     = stg_cnt_q;
					gen_d        = gen_q + 64'd1;
					stg_base_d   = 64'd0;
					stg_kind_d   = CLS_UNKNOWN;
					stg_cnt_d    = '0;
					res_status_d = ST_DONE;
					state_d      = S_FINISH;
				end else if (p_q < stg_cnt_q) begin
					pend_d = 1'b1;
					ppos_d = p_q[RNG_IDX_W-1:0];
					p_d    = p_q + RNG_CNT_W'(1);
				end
			end

			S_UREAD: begin
				img_raddr = src_q;
				state_d   = S_UMOVE;
			end

			S_UMOVE: begin
				img_we  = 1'b1;
				n_d     = img_rd_cnt_q;
				p_d     = '0;
				state_d = S_UCOPY;
			end

			S_UCOPY: begin
				rng_raddr = rng_addr(src_q, p_q[RNG_IDX_W-1:0]);
				rng_we    = pend_q;
				rng_wlo   = rng_rd_lo_q;
				rng_whi   = rng_rd_hi_q;
				if (!pend_q && p_q >= n_q) begin
					gen_d        = gen_q + 64'd1;
					res_status_d = ST_DONE;
					state_d      = S_FINISH;
				end else if (p_q < n_q) begin
					pend_d = 1'b1;
					ppos_d = p_q[RNG_IDX_W-1:0];
					p_d    = p_q + RNG_CNT_W'(1);
				end
			end

			S_LIMG: state_d = S_LHDR;

			S_LHDR: begin
				n_d     = img_rd_cnt_q;
				kind_d  = img_rd_kind_q;
				p_d     = '0;
				state_d = S_LRNG;
			end

			S_LRNG: begin
				if (range_match) begin
					res_status_d = ST_DONE;
					res_hit_d    = 1'b1;
					res_lo_d     = rng_rd_lo_q;
					res_hi_d     = rng_rd_hi_q;
					res_cls_d    = kind_q;
					state_d      = S_FINISH;
				end else if (!pend_q && p_q >= n_q) begin
					if ((i_q + IMG_CNT_W'(1)) >= img_cnt_q) begin
						state_d = S_FINISH;
					end else begin
						i_d     = i_q + IMG_CNT_W'(1);
						state_d = S_LIMG;
					end
				end else if (p_q < n_q) begin
					pend_d = 1'b1;
					p_d    = p_q + RNG_CNT_W'(1);
				end
			end

			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					out_load    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end

			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			img_cnt_q   <= '0;
			gen_q       <= 64'd1;
			stg_base_q  <= 64'd0;
			stg_kind_q  <= CLS_UNKNOWN;
			stg_cnt_q   <= '0;
			i_q         <= '0;
			p_q         <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			img_cnt_q   <= img_cnt_d;
			gen_q       <= gen_d;
			stg_base_q  <= stg_base_d;
			stg_kind_q  <= stg_kind_d;
			stg_cnt_q   <= stg_cnt_d;
			i_q         <= i_d;
			p_q         <= p_d;
			pend_q      <= pend_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		bias_q       <= bias_d;
		addr_q       <= addr_d;
		pidx_q       <= pidx_d;
		ppos_q       <= ppos_d;
		tgt_q        <= tgt_d;
		src_q        <= src_d;
		n_q          <= n_d;
		kind_q       <= kind_d;
		res_status_q <= res_status_d;
		res_hit_q    <= res_hit_d;
		res_lo_q     <= res_lo_d;
		res_hi_q     <= res_hi_d;
		res_cls_q    <= res_cls_d;
		if (out_load) begin
			out_status_q <= res_status_q;
			out_hit_q    <= res_hit_q;
			out_lo_q     <= res_lo_q;
			out_hi_q     <= res_hi_q;
			out_cls_q    <= res_cls_q;
			out_gen_q    <= gen_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = out_status_q;
	assign hit              = out_hit_q;
	assign range_start      = out_lo_q;
	assign range_end        = out_hi_q;
	assign class_out        = out_cls_q;
	assign generation_count = out_gen_q;

endmodule
